FILE: rtl/dfs_maze_generator_macros.svh
// ----------------------------------------------------------------------------
// dfs_maze_generator_macros.svh
// Assertion macros shared by the maze generator RTL.
// ----------------------------------------------------------------------------
`ifndef DFS_MAZE_GENERATOR_MACROS_SVH
`define DFS_MAZE_GENERATOR_MACROS_SVH

`ifndef SYNTHESIS
// Antecedent implies consequent in the same cycle.
`define DFS_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Antecedent implies consequent in the next cycle.
`define DFS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define DFS_ASSERT_IMPL(lbl, ante, cons, msg)
`define DFS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

FILE: rtl/dfs_pkg.sv
// ----------------------------------------------------------------------------
// dfs_pkg
// Grid geometry, field widths, codes and types of the maze generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dfs_pkg;

    // Grid geometry
    localparam int ROOMS_X    = 32;
    localparam int ROOMS_Y    = 16;
    localparam int X_W        = $clog2(ROOMS_X);
    localparam int Y_W        = $clog2(ROOMS_Y);
    localparam int ROOM_W     = X_W + Y_W;
    localparam int ROOM_SLOTS = 1 << ROOM_W;
    localparam int ROOM_COUNT = ROOMS_X * ROOMS_Y;
    localparam int SP_W       = $clog2(ROOM_COUNT + 1);
    localparam int CO_W       = ((X_W > Y_W) ? X_W : Y_W) + 1;

    // Beat field widths
    localparam int OPC_W      = 1;
    localparam int DIR_W      = 2;
    localparam int STATUS_W   = 2;
    localparam int CX_W       = 7;
    localparam int CY_W       = 6;
    localparam int DEPTH_W    = 10;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;
    localparam int START_X_W  = 5;
    localparam int START_Y_W  = 4;

    // Opcodes
    localparam logic [OPC_W-1:0] OP_DRAW    = 1'b0;
    localparam logic [OPC_W-1:0] OP_RESTART = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_ENTER   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RESTART = 2'd1;
    localparam logic [STATUS_W-1:0] ST_IGNORED = 2'd2;

    // Scan directions
    localparam logic [DIR_W-1:0] DIR_N    = 2'd0;
    localparam logic [DIR_W-1:0] DIR_S    = 2'd1;
    localparam logic [DIR_W-1:0] DIR_E    = 2'd2;
    localparam logic [DIR_W-1:0] DIR_WEST = 2'd3;

    // Walk phases
    localparam logic [1:0] PH_IDLE    = 2'd0;
    localparam logic [1:0] PH_PENDING = 2'd1;
    localparam logic [1:0] PH_DONE    = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_START_X = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_Y = 1'b1;

    typedef struct packed {
        logic [Y_W-1:0] y;
        logic [X_W-1:0] x;
    } t_room;

    // One walk stack entry: room, first scan direction, directions tried
    typedef struct packed {
        t_room            room;
        logic [DIR_W-1:0] first;
        logic [DIR_W-1:0] tried;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        t_room            room;
        logic [DIR_W-1:0] dir;
    } t_nbr_req;

    typedef struct packed {
        logic  ok;
        t_room room;
    } t_nbr_rsp;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [CX_W-1:0]     cell_x;
        logic [CY_W-1:0]     cell_y;
        logic                has_wall;
        logic [CX_W-1:0]     wall_x;
        logic [CY_W-1:0]     wall_y;
        logic [DEPTH_W-1:0]  depth;
        logic                complete;
        logic [CX_W-1:0]     goal_x;
        logic [CY_W-1:0]     goal_y;
        logic [DEPTH_W-1:0]  peak_depth;
    } t_result;

    // Grid column of a room: 2x+1
    function automatic logic [CX_W-1:0] cell_x(input logic [X_W-1:0] x);
        logic [X_W:0] t;
        t = {x, 1'b1};
        return CX_W'(t);
    endfunction

    // Grid row of a room: 2y+1
    function automatic logic [CY_W-1:0] cell_y(input logic [Y_W-1:0] y);
        logic [Y_W:0] t;
        t = {y, 1'b1};
        return CY_W'(t);
    endfunction

endpackage

FILE: rtl/dfs_if.sv
// ----------------------------------------------------------------------------
// dfs_if
// Valid/ready channels of the maze generator: input, result and config.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface dfs_in_if;
    logic                         valid;
    logic                         ready;
    logic [dfs_pkg::OPC_W-1:0]    opcode;
    logic [dfs_pkg::DIR_W-1:0]    draw;

    modport source (output valid, opcode, draw, input ready);
    modport sink   (input valid, opcode, draw, output ready);
endinterface

interface dfs_out_if;
    logic                          valid;
    logic                          ready;
    logic [dfs_pkg::STATUS_W-1:0]  status;
    logic [dfs_pkg::CX_W-1:0]      cell_x;
    logic [dfs_pkg::CY_W-1:0]      cell_y;
    logic                          has_wall;
    logic [dfs_pkg::CX_W-1:0]      wall_x;
    logic [dfs_pkg::CY_W-1:0]      wall_y;
    logic [dfs_pkg::DEPTH_W-1:0]   depth;
    logic                          complete;
    logic [dfs_pkg::CX_W-1:0]      goal_x;
    logic [dfs_pkg::CY_W-1:0]      goal_y;
    logic [dfs_pkg::DEPTH_W-1:0]   peak_depth;

    modport source (output valid, status, cell_x, cell_y, has_wall, wall_x, wall_y,
                    depth, complete, goal_x, goal_y, peak_depth, input ready);
    modport sink   (input valid, status, cell_x, cell_y, has_wall, wall_x, wall_y,
                    depth, complete, goal_x, goal_y, peak_depth, output ready);
endinterface

interface dfs_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [dfs_pkg::CFG_IDX_W-1:0]   index;
    logic [dfs_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/dfs_ram.sv
// ----------------------------------------------------------------------------
// dfs_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dfs_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/dfs_nbr.sv
// ----------------------------------------------------------------------------
// dfs_nbr
// Neighbour unit: one shared +/-1 adder and bound compare on room coordinates.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dfs_nbr (
    input  dfs_pkg::t_nbr_req i_req,
    output dfs_pkg::t_nbr_rsp o_rsp
);
    import dfs_pkg::*;

    logic            w_sel_y;
    logic            w_dec;
    logic [CO_W-1:0] w_opnd;
    logic [CO_W-1:0] w_limit;
    logic [CO_W-1:0] w_sum;

    always_comb begin
        w_sel_y = (i_req.dir == DIR_N) || (i_req.dir == DIR_S);
        w_dec   = (i_req.dir == DIR_N) || (i_req.dir == DIR_WEST);
        w_opnd  = w_sel_y ? CO_W'(i_req.room.y) : CO_W'(i_req.room.x);
        w_limit = w_sel_y ? CO_W'(ROOMS_Y) : CO_W'(ROOMS_X);
        w_sum   = w_dec ? (w_opnd - CO_W'(1)) : (w_opnd + CO_W'(1));

        o_rsp.ok   = w_dec ? (w_opnd != '0) : (w_sum < w_limit);
        o_rsp.room = i_req.room;
        if (w_sel_y) begin
            o_rsp.room.y = w_sum[Y_W-1:0];
        end else begin
            o_rsp.room.x = w_sum[X_W-1:0];
        end
    end

endmodule

FILE: rtl/dfs_maze_generator.sv
// ----------------------------------------------------------------------------
// dfs_maze_generator
// Randomized depth-first maze carver (recursive backtracker) with an explicit
// walk stack in RAM, driven one room per draw beat.
// ----------------------------------------------------------------------------
// A restart beat clears the visited map and makes the configured start room
// pending; a draw beat enters the pending room, reports it with the wall that
// was knocked down and its depth, then backtracks through the walk stack until
// an unvisited neighbour becomes pending or the stack empties (complete), with
// the goal fields valid in either case. A restart beat sweeps the visited map
// one room per cycle; an ignored draw goes straight to the output stage; an
// accepted draw makes one or more neighbour probes, and every room on the
// stack gets four probes over the whole walk, the fourth of which pops it.
// Each probe passes through S_VREQ and then S_VCHK: the visited map and the
// walk stack both have a registered read port, and the neighbour unit is
// shared by all probes. Input is not taken while a beat is being worked on; a
// finished result sits in an output register, so the next beat can be
// accepted before the previous result is taken. Config writes are always
// accepted and must only happen while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "dfs_maze_generator_macros.svh"

module dfs_maze_generator (
    input  logic      i_clk,
    input  logic      i_rst_n,
    dfs_cfg_if.sink   i_cfg,
    dfs_in_if.sink    i_in,
    dfs_out_if.source o_out
);
    import dfs_pkg::*;

    // Sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;  // waiting for an input beat
    localparam logic [2:0] S_CLEAR = 3'd1;  // visited map sweep after restart
    localparam logic [2:0] S_VREQ  = 3'd2;  // probe neighbour, update stack top
    localparam logic [2:0] S_VCHK  = 3'd3;  // check visited bit, pick next step
    localparam logic [2:0] S_OUT   = 3'd4;  // hand result to output register

    // Control registers
    logic [2:0]           r_state,     n_state;
    logic [START_X_W-1:0] r_start_x;
    logic [START_Y_W-1:0] r_start_y;
    logic [1:0]           r_phase,     n_phase;
    t_room                r_pend,      n_pend;
    logic                 r_pend_wall, n_pend_wall;
    logic [DIR_W-1:0]     r_pend_dir,  n_pend_dir;
    logic [SP_W-1:0]      r_sp,        n_sp;
    logic [DEPTH_W-1:0]   r_deep,      n_deep;
    t_room                r_goal,      n_goal;
    logic [ROOM_W-1:0]    r_clr,       n_clr;
    logic                 r_out_valid, n_out_valid;

    // Payload registers
    t_entry               r_top,       n_top;
    logic                 r_popped,    n_popped;
    t_nbr_rsp             r_nbr,       n_nbr;
    logic [DIR_W-1:0]     r_nbr_dir,   n_nbr_dir;
    t_result              r_res,       n_res;
    t_result              r_out,       n_out;

    // Memory ports
    logic              w_vis_we;
    logic [ROOM_W-1:0] w_vis_waddr;
    logic [0:0]        w_vis_wdata;
    logic [ROOM_W-1:0] w_vis_raddr;
    logic [0:0]        w_vis_rdata;
    logic              w_stk_we;
    logic [ROOM_W-1:0] w_stk_waddr;
    t_entry            w_stk_wdata;
    logic [ROOM_W-1:0] w_stk_raddr;
    logic [ENTRY_W-1:0] w_stk_rdata;

    // Neighbour unit
    t_nbr_req          w_nbr_req;
    t_nbr_rsp          w_nbr_rsp;

    // Helpers
    logic               w_in_fire;
    t_room              w_start;
    logic [CX_W-1:0]    w_cx;
    logic [CY_W-1:0]    w_cy;
    logic [SP_W-1:0]    w_sp_inc;
    logic [DEPTH_W-1:0] w_depth;
    logic [SP_W-1:0]    w_sp_dec2;

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign w_in_fire   = i_in.valid && i_in.ready;

    // Saturate the start room into the grid
    always_comb begin
        w_start.x = (8'(r_start_x) < 8'(ROOMS_X)) ? X_W'(r_start_x) : X_W'(ROOMS_X - 1);
        w_start.y = (8'(r_start_y) < 8'(ROOMS_Y)) ? Y_W'(r_start_y) : Y_W'(ROOMS_Y - 1);
    end

    assign w_cx      = cell_x(r_pend.x);
    assign w_cy      = cell_y(r_pend.y);
    assign w_sp_inc  = r_sp + SP_W'(1);
    assign w_depth   = DEPTH_W'(w_sp_inc);
    assign w_sp_dec2 = r_sp - SP_W'(2);

    // Probe the stack top in the direction it has reached so far
    assign w_nbr_req.room = r_top.room;
    assign w_nbr_req.dir  = r_top.first + r_top.tried;

    dfs_nbr u_nbr (
        .i_req (w_nbr_req),
        .o_rsp (w_nbr_rsp)
    );

    dfs_ram #(
        .WIDTH (1),
        .DEPTH (ROOM_SLOTS)
    ) u_visited (
        .i_clk   (i_clk),
        .i_we    (w_vis_we),
        .i_waddr (w_vis_waddr),
        .i_wdata (w_vis_wdata),
        .i_raddr (w_vis_raddr),
        .o_rdata (w_vis_rdata)
    );

    dfs_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ROOM_SLOTS)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (w_stk_we),
        .i_waddr (w_stk_waddr),
        .i_wdata (w_stk_wdata),
        .i_raddr (w_stk_raddr),
        .o_rdata (w_stk_rdata)
    );

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_pend      = r_pend;
        n_pend_wall = r_pend_wall;
        n_pend_dir  = r_pend_dir;
        n_sp        = r_sp;
        n_deep      = r_deep;
        n_goal      = r_goal;
        n_clr       = r_clr;
        n_top       = r_top;
        n_popped    = r_popped;
        n_nbr       = r_nbr;
        n_nbr_dir   = r_nbr_dir;
        n_res       = r_res;
        n_out       = r_out;
        // Drop the output beat once it is taken
        n_out_valid = r_out_valid && !o_out.ready;

        w_vis_we    = 1'b0;
        w_vis_waddr = r_pend;
        w_vis_wdata = 1'b1;
        w_vis_raddr = w_nbr_rsp.room;
        w_stk_we    = 1'b0;
        w_stk_waddr = r_sp[ROOM_W-1:0];
        w_stk_wdata = r_top;
        w_stk_raddr = w_sp_dec2[ROOM_W-1:0];

        case (r_state)
            S_IDLE: begin
                if (w_in_fire) begin
                    if (i_in.opcode == OP_RESTART) begin
                        // Abandon any walk, then sweep the visited map
                        n_phase     = PH_PENDING;
                        n_pend      = w_start;
                        n_pend_wall = 1'b0;
                        n_pend_dir  = DIR_N;
                        n_sp        = '0;
                        n_deep      = '0;
                        n_goal      = '0;
                        n_clr       = '0;
                        n_res        = '0;
                        n_res.status = ST_RESTART;
                        n_state     = S_CLEAR;
                    end else if ((r_phase != PH_PENDING) || (r_sp >= SP_W'(ROOM_COUNT))) begin
                        n_res        = '0;
                        n_res.status = ST_IGNORED;
                        n_state      = S_OUT;
                    end else begin
                        // Enter the pending room and push it
                        n_res          = '0;
                        n_res.status   = ST_ENTER;
                        n_res.cell_x   = w_cx;
                        n_res.cell_y   = w_cy;
                        n_res.has_wall = r_pend_wall;
                        n_res.depth    = w_depth;
                        if (r_pend_wall) begin
                            n_res.wall_x = w_cx;
                            n_res.wall_y = w_cy;
                            case (r_pend_dir)
                                DIR_N:   n_res.wall_y = w_cy + CY_W'(1);
                                DIR_S:   n_res.wall_y = w_cy - CY_W'(1);
                                DIR_E:   n_res.wall_x = w_cx - CX_W'(1);
                                default: n_res.wall_x = w_cx + CX_W'(1);
                            endcase
                        end
                        if (w_depth > r_deep) begin
                            n_deep = w_depth;
                            n_goal = r_pend;
                        end
                        w_vis_we          = 1'b1;
                        w_stk_we          = 1'b1;
                        w_stk_wdata.room  = r_pend;
                        w_stk_wdata.first = i_in.draw;
                        w_stk_wdata.tried = '0;
                        n_top       = w_stk_wdata;
                        n_sp        = w_sp_inc;
                        n_state     = S_VREQ;
                    end
                end
            end

            S_CLEAR: begin
                w_vis_we    = 1'b1;
                w_vis_waddr = r_clr;
                w_vis_wdata = 1'b0;
                n_clr       = r_clr + ROOM_W'(1);
                if (r_clr == '1) begin
                    n_state = S_OUT;
                end
            end

            S_VREQ: begin
                // Visited read is issued at the neighbour address
                n_nbr     = w_nbr_rsp;
                n_nbr_dir = w_nbr_req.dir;
                if (r_top.tried == 2'd3) begin
                    // Last direction: pop, fetch the entry below
                    n_sp     = r_sp - SP_W'(1);
                    n_popped = 1'b1;
                end else begin
                    // Advance and write the top back for later backtracking
                    n_top.tried = r_top.tried + 2'd1;
                    w_stk_we    = 1'b1;
                    w_stk_waddr = w_sp_dec2[ROOM_W-1:0] + ROOM_W'(1);
                    w_stk_wdata = n_top;
                    n_popped    = 1'b0;
                end
                n_state = S_VCHK;
            end

            S_VCHK: begin
                if (r_nbr.ok && !w_vis_rdata[0]) begin
                    n_pend       = r_nbr.room;
                    n_pend_wall  = 1'b1;
                    n_pend_dir   = r_nbr_dir;
                    n_res.goal_x     = cell_x(r_goal.x);
                    n_res.goal_y     = cell_y(r_goal.y);
                    n_res.peak_depth = r_deep;
                    n_state      = S_OUT;
                end else if (r_sp == '0) begin
                    // Stack empty: walk finished
                    n_phase          = PH_DONE;
                    n_pend_wall      = 1'b0;
                    n_res.complete   = 1'b1;
                    n_res.goal_x     = cell_x(r_goal.x);
                    n_res.goal_y     = cell_y(r_goal.y);
                    n_res.peak_depth = r_deep;
                    n_state          = S_OUT;
                end else begin
                    if (r_popped) begin
                        n_top = t_entry'(w_stk_rdata);
                    end
                    n_state = S_VREQ;
                end
            end

            S_OUT: begin
                // Hold until the output register is free
                if (!r_out_valid || o_out.ready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_start_x   <= '0;
            r_start_y   <= '0;
            r_phase     <= PH_IDLE;
            r_pend      <= '0;
            r_pend_wall <= 1'b0;
            r_pend_dir  <= DIR_N;
            r_sp        <= '0;
            r_deep      <= '0;
            r_goal      <= '0;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_pend      <= n_pend;
            r_pend_wall <= n_pend_wall;
            r_pend_dir  <= n_pend_dir;
            r_sp        <= n_sp;
            r_deep      <= n_deep;
            r_goal      <= n_goal;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    CFG_START_X: r_start_x <= i_cfg.data[START_X_W-1:0];
                    CFG_START_Y: r_start_y <= i_cfg.data[START_Y_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_top     <= n_top;
        r_popped  <= n_popped;
        r_nbr     <= n_nbr;
        r_nbr_dir <= n_nbr_dir;
        r_res     <= n_res;
        r_out     <= n_out;
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.status     = r_out.status;
    assign o_out.cell_x     = r_out.cell_x;
    assign o_out.cell_y     = r_out.cell_y;
    assign o_out.has_wall   = r_out.has_wall;
    assign o_out.wall_x     = r_out.wall_x;
    assign o_out.wall_y     = r_out.wall_y;
    assign o_out.depth      = r_out.depth;
    assign o_out.complete   = r_out.complete;
    assign o_out.goal_x     = r_out.goal_x;
    assign o_out.goal_y     = r_out.goal_y;
    assign o_out.peak_depth = r_out.peak_depth;

    // Assertions
    `DFS_ASSERT_NEXT(a_restart_clears, w_in_fire && (i_in.opcode == OP_RESTART), r_state == S_CLEAR, "restart beat did not start the visited sweep")
    `DFS_ASSERT_IMPL(a_sp_bound, 1'b1, r_sp <= SP_W'(ROOM_COUNT), "walk stack pointer beyond room count")
    `DFS_ASSERT_IMPL(a_done_empty, r_phase == PH_DONE, r_sp == '0, "finished walk with a non-empty stack")
    `DFS_ASSERT_IMPL(a_goal_depth, r_out_valid && (r_out.status == ST_ENTER), r_out.peak_depth >= r_out.depth, "entered room deeper than the reported maximum")
    `DFS_ASSERT_NEXT(a_probe_check, r_state == S_VREQ, r_state == S_VCHK, "neighbour probe not followed by visited check")

endmodule

FILE: sim/dfs_maze_generator_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfs_maze_generator_test
// Self-checking bench for the depth-first maze carver: drives restart and
// draw beats, writes the start room, predicts every result and checks it.
// ----------------------------------------------------------------------------
// A scoreboard class holds a private copy of the carver state (visited map,
// walk stack, goal tracking) and the queue of results still due. The input
// and result sides idle at random, with quiet stretches, and the result side
// holds off twice for a long stretch so the block backs up and stalls input.
// ----------------------------------------------------------------------------

module dfs_maze_generator_test;
    import dfs_pkg::*;

    localparam int CLK_HALF     = 2;
    localparam int RESET_CYCLES = 6;
    localparam int ITEMS_WANTED = 1800;
    localparam int CYCLE_LIMIT  = 4_000_000;
    localparam int HOLD_CYCLES  = 300;
    localparam int TAIL_CYCLES  = 64;
    localparam int MAX_GAP      = 13;
    localparam int REPORT_MAX   = 10;

    // Scan directions as carried on the draw field
    typedef enum logic [1:0] {HEAD_N, HEAD_S, HEAD_E, HEAD_W} t_heading;

    // ------------------------------------------------------------------------
    // Carver scoreboard: mirrors the walk and checks results in order
    // ------------------------------------------------------------------------
    class maze_tracker;
        bit                   seen [ROOM_COUNT];
        t_entry               trail [ROOM_COUNT];
        int unsigned          depth_now;
        t_room                next_room;
        logic [1:0]           walk_ph;
        int unsigned          best_depth;
        t_room                best_room;
        bit                   via_wall;
        logic [1:0]           via_dir;
        logic [START_X_W-1:0] start_x;
        logic [START_Y_W-1:0] start_y;
        t_result              reports_due [$];
        int unsigned          errors;

        function new();
            seen       = '{default: 1'b0};
            depth_now  = 0;
            next_room  = '0;
            walk_ph    = PH_IDLE;
            best_depth = 0;
            best_room  = '0;
            via_wall   = 1'b0;
            via_dir    = HEAD_N;
            start_x    = '0;
            start_y    = '0;
            errors     = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            if (idx == CFG_START_X) begin
                start_x = val[START_X_W-1:0];
            end else if (idx == CFG_START_Y) begin
                start_y = val[START_Y_W-1:0];
            end
        endfunction

        // Neighbor of a room in one direction; 0 if it falls off the grid
        function bit step_to(t_room r, logic [1:0] d, output t_room nb);
            nb = r;
            case (d)
                HEAD_N: begin
                    if (r.y == 0) return 1'b0;
                    nb.y = r.y - 1'b1;
                end
                HEAD_S: begin
                    if (int'(r.y) + 1 >= ROOMS_Y) return 1'b0;
                    nb.y = r.y + 1'b1;
                end
                HEAD_E: begin
                    if (int'(r.x) + 1 >= ROOMS_X) return 1'b0;
                    nb.x = r.x + 1'b1;
                end
                default: begin
                    if (r.x == 0) return 1'b0;
                    nb.x = r.x - 1'b1;
                end
            endcase
            return 1'b1;
        endfunction

        // Advance the walk by one beat and return the result it produces
        function t_result predict_carve(logic [OPC_W-1:0] op, logic [1:0] dr);
            t_result     res;
            t_room       r;
            t_room       nb;
            logic [1:0]  d;
            bit          found;
            int unsigned cx;
            int unsigned cy;
            int unsigned wx;
            int unsigned wy;
            res = '0;
            if (op == OP_RESTART) begin
                seen       = '{default: 1'b0};
                depth_now  = 0;
                best_depth = 0;
                best_room  = '0;
                via_wall   = 1'b0;
                via_dir    = HEAD_N;
                next_room.x = (int'(start_x) < ROOMS_X) ? start_x : X_W'(ROOMS_X - 1);
                next_room.y = (int'(start_y) < ROOMS_Y) ? start_y : Y_W'(ROOMS_Y - 1);
                walk_ph    = PH_PENDING;
                res.status = ST_RESTART;
                return res;
            end
            if (walk_ph != PH_PENDING || depth_now >= ROOM_COUNT) begin
                res.status = ST_IGNORED;
                return res;
            end

            r  = next_room;
            cx = 2 * r.x + 1;
            cy = 2 * r.y + 1;
            if (depth_now + 1 > best_depth) begin
                best_depth = depth_now + 1;
                best_room  = r;
            end
            seen[int'(r)]          = 1'b1;
            trail[depth_now].room  = r;
            trail[depth_now].first = dr;
            trail[depth_now].tried = '0;
            depth_now++;

            res.status = ST_ENTER;
            res.cell_x = CX_W'(cx);
            res.cell_y = CY_W'(cy);
            res.depth  = DEPTH_W'(depth_now);
            if (via_wall) begin
                wx = cx;
                wy = cy;
                case (via_dir)
                    HEAD_N:  wy = cy + 1;
                    HEAD_S:  wy = cy - 1;
                    HEAD_E:  wx = cx - 1;
                    default: wx = cx + 1;
                endcase
                res.has_wall = 1'b1;
                res.wall_x   = CX_W'(wx);
                res.wall_y   = CY_W'(wy);
            end

            // Backtrack: try the top room's next direction, pop once all four are spent
            found = 1'b0;
            while (depth_now > 0 && !found) begin
                d = trail[depth_now-1].first + trail[depth_now-1].tried;
                r = trail[depth_now-1].room;
                if (trail[depth_now-1].tried == 2'd3) depth_now--;
                else trail[depth_now-1].tried++;
                if (step_to(r, d, nb) && !seen[int'(nb)]) begin
                    next_room = nb;
                    via_wall  = 1'b1;
                    via_dir   = d;
                    found     = 1'b1;
                end
            end
            if (!found) begin
                walk_ph      = PH_DONE;
                via_wall     = 1'b0;
                res.complete = 1'b1;
            end
            res.goal_x     = CX_W'(2 * best_room.x + 1);
            res.goal_y     = CY_W'(2 * best_room.y + 1);
            res.peak_depth = DEPTH_W'(best_depth);
            return res;
        endfunction

        function logic [STATUS_W-1:0] note_beat(logic [OPC_W-1:0] op, logic [1:0] dr);
            t_result res;
            res = predict_carve(op, dr);
            reports_due.push_back(res);
            return res.status;
        endfunction

        function string diff_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) return $sformatf(" %s exp %0d got %0d", name, want, got);
            return "";
        endfunction

        function void check_beat(t_result got);
            t_result want;
            string   diffs;
            if (reports_due.size() == 0) begin
                errors++;
                if (errors <= REPORT_MAX) $display("unexpected result beat: %p", got);
                return;
            end
            want  = reports_due.pop_front();
            diffs = {diff_field("status", want.status, got.status),
                     diff_field("cell_x", want.cell_x, got.cell_x),
                     diff_field("cell_y", want.cell_y, got.cell_y),
                     diff_field("has_wall", want.has_wall, got.has_wall),
                     diff_field("wall_x", want.wall_x, got.wall_x),
                     diff_field("wall_y", want.wall_y, got.wall_y),
                     diff_field("depth", want.depth, got.depth),
                     diff_field("complete", want.complete, got.complete),
                     diff_field("goal_x", want.goal_x, got.goal_x),
                     diff_field("goal_y", want.goal_y, got.goal_y),
                     diff_field("peak_depth", want.peak_depth, got.peak_depth)};
            if (diffs != "") begin
                errors++;
                if (errors <= REPORT_MAX) $display("result beat mismatch:%s", diffs);
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, channels and the block
    // ------------------------------------------------------------------------
    logic i_clk;
    logic i_rst_n;

    dfs_in_if  in_ch ();
    dfs_out_if res_ch ();
    dfs_cfg_if cfg_ch ();

    dfs_maze_generator dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_ch),
        .i_in    (in_ch),
        .o_out   (res_ch)
    );

    maze_tracker sb;

    bit          in_lazy;      // input side idles between beats
    bit          out_lazy;     // result side idles between beats
    bit          in_up;        // input valid is currently held high
    realtime     in_drop_at;   // when input valid was last dropped
    int unsigned useful;       // accepted beats that the block did not ignore
    int unsigned cycles;

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Watchdog: end the run if the block hangs or results go missing
    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------
    // Offer one beat after a random gap; valid stays high into the next beat
    // when no gap follows, so back-to-back beats need no drop in between.
    task automatic send_beat(logic [OPC_W-1:0] op, logic [1:0] dr);
        int gap;
        gap = in_lazy ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0) begin
            if (in_up) begin
                in_ch.valid <= 1'b0;
                in_up = 1'b0;
            end
            repeat (gap) @(posedge i_clk);
        end else if (!in_up && in_drop_at == $realtime) begin
            // valid was dropped in this very step; raise it on the next edge
            @(posedge i_clk);
        end
        in_ch.valid  <= 1'b1;
        in_ch.opcode <= op;
        in_ch.draw   <= dr;
        in_up = 1'b1;
        do @(posedge i_clk); while (!in_ch.ready);
        if (sb.note_beat(op, dr) != ST_IGNORED) useful++;
    endtask

    task automatic send_draw();
        send_beat(OP_DRAW, 2'($urandom_range(0, 3)));
    endtask

    task automatic release_input();
        if (in_up) begin
            in_ch.valid <= 1'b0;
            in_up = 1'b0;
            in_drop_at = $realtime;
        end
    endtask

    // Hold input and wait until every predicted result has been taken
    task automatic drain();
        release_input();
        while (sb.reports_due.size() != 0) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Register writes (only while the block is idle)
    // ------------------------------------------------------------------------
    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        repeat ($urandom_range(1, 4)) @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        sb.write_reg(idx, val);
    endtask

    // The row register is narrower than the data bus; toggle the spare bit too
    task automatic set_start(logic [START_X_W-1:0] x, logic [START_Y_W-1:0] y);
        cfg_write(CFG_START_X, CFG_DATA_W'(x));
        cfg_write(CFG_START_Y, {1'($urandom_range(0, 1)), y});
    endtask

    // ------------------------------------------------------------------------
    // Result side: random stalls, two long hold-offs to back up the block
    // ------------------------------------------------------------------------
    initial begin
        int          stall;
        int unsigned taken;
        t_result     got;
        taken        = 0;
        out_lazy     = 1'b1;
        res_ch.ready = 1'b0;
        do @(posedge i_clk); while (i_rst_n !== 1'b1);
        forever begin
            if (taken == 30 || taken == 1200) stall = HOLD_CYCLES;
            else stall = out_lazy ? $urandom_range(0, MAX_GAP) : 0;
            if (stall > 0) begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!res_ch.valid);
            got.status     = res_ch.status;
            got.cell_x     = res_ch.cell_x;
            got.cell_y     = res_ch.cell_y;
            got.has_wall   = res_ch.has_wall;
            got.wall_x     = res_ch.wall_x;
            got.wall_y     = res_ch.wall_y;
            got.depth      = res_ch.depth;
            got.complete   = res_ch.complete;
            got.goal_x     = res_ch.goal_x;
            got.goal_y     = res_ch.goal_y;
            got.peak_depth = res_ch.peak_depth;
            sb.check_beat(got);
            taken++;
            // switch between stalling and streaming every hundred results
            if (taken % 100 == 0) out_lazy = ($urandom_range(0, 3) != 0);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        bit first_walk;
        int n;
        in_ch.valid  = 1'b0;
        in_ch.opcode = OP_DRAW;
        in_ch.draw   = HEAD_N;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = CFG_START_X;
        cfg_ch.data  = '0;
        in_up        = 1'b0;
        in_drop_at   = -1.0;
        in_lazy      = 1'b1;
        useful       = 0;
        sb           = new();

        i_rst_n = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: draws before any restart are ignored; walk from the
        // reset start room in the top-left corner, then abandon it
        send_beat(OP_DRAW, HEAD_N);
        send_beat(OP_DRAW, HEAD_W);
        send_beat(OP_RESTART, HEAD_N);
        send_beat(OP_DRAW, HEAD_N);
        send_beat(OP_DRAW, HEAD_S);
        send_beat(OP_DRAW, HEAD_E);
        send_beat(OP_DRAW, HEAD_W);
        send_beat(OP_RESTART, HEAD_E);
        send_beat(OP_DRAW, HEAD_E);
        drain();

        // Directed: start in the far corner, restart mid-walk and back to back
        set_start(X_W'(ROOMS_X - 1), Y_W'(ROOMS_Y - 1));
        send_beat(OP_RESTART, HEAD_S);
        send_beat(OP_DRAW, HEAD_W);
        send_beat(OP_DRAW, HEAD_E);
        send_beat(OP_DRAW, HEAD_S);
        send_beat(OP_DRAW, HEAD_N);
        send_beat(OP_RESTART, HEAD_W);
        send_beat(OP_RESTART, HEAD_N);
        send_beat(OP_DRAW, HEAD_N);
        send_beat(OP_DRAW, HEAD_S);
        send_beat(OP_DRAW, HEAD_E);
        send_beat(OP_DRAW, HEAD_W);

        // Random phases: mostly whole walks with random draws, some cut short
        first_walk = 1'b1;
        while (useful < ITEMS_WANTED) begin
            drain();
            case ($urandom_range(0, 3))
                0:       set_start('0, '0);
                1:       set_start(X_W'(ROOMS_X - 1), Y_W'(ROOMS_Y - 1));
                default: set_start(X_W'($urandom_range(0, ROOMS_X - 1)),
                                   Y_W'($urandom_range(0, ROOMS_Y - 1)));
            endcase
            in_lazy = ($urandom_range(0, 3) != 0);

            // stray draws ahead of the restart: ignored or carry on the old walk
            if ($urandom_range(0, 3) == 0) begin
                repeat ($urandom_range(1, 3)) send_draw();
            end

            if (first_walk ||
                ($urandom_range(0, 9) < 4 && ITEMS_WANTED - useful >= ROOM_COUNT + 4)) begin
                // full walk: every room entered, last one completes, then idle draws
                send_beat(OP_RESTART, 2'($urandom_range(0, 3)));
                repeat (ROOM_COUNT) send_draw();
                repeat ($urandom_range(1, 3)) send_draw();
            end else begin
                // partial walk with the odd restart thrown in
                send_beat(OP_RESTART, 2'($urandom_range(0, 3)));
                n = $urandom_range(1, 150);
                repeat (n) begin
                    if ($urandom_range(0, 19) == 0) send_beat(OP_RESTART, 2'($urandom_range(0, 3)));
                    else send_draw();
                end
            end
            first_walk = 1'b0;
        end

        // Wind down: take every result, then watch for strays
        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.reports_due.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
